@@ sv/led_blink_manager_macros.svh @@
// ----------------------------------------------------------------------------
// LED blink manager assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_MANAGER_MACROS_SVH
`define LED_BLINK_MANAGER_MACROS_SVH

// Check that is switched off while reset is high
`define LBM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also holds while reset is high
`define LBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/lbm_pkg.sv @@
// ----------------------------------------------------------------------------
// LED blink manager package
// Request and response types, state record, command codes and pin masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbm_pkg;

   // Command codes
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_ON      = 3'd1;
   localparam logic [2:0] OP_OFF     = 3'd2;
   localparam logic [2:0] OP_BLINK   = 3'd3;
   localparam logic [2:0] OP_ALT     = 3'd4;
   localparam logic [2:0] OP_ALL_ON  = 3'd5;
   localparam logic [2:0] OP_ALL_OFF = 3'd6;

   // LED indexes
   localparam logic [1:0] LED_RED   = 2'd0;
   localparam logic [1:0] LED_GREEN = 2'd1;
   localparam logic [1:0] LED_DRV1  = 2'd2;
   localparam logic [1:0] LED_DRV2  = 2'd3;
   localparam logic [3:0] LED_COUNT = 4'd4;

   // Pin bits
   localparam logic [3:0] PIN_RED   = 4'h1;
   localparam logic [3:0] PIN_GREEN = 4'h2;
   localparam logic [3:0] PIN_DISK2 = 4'h4;
   localparam logic [3:0] PIN_DISK1 = 4'h8;

   // Reset values
   localparam logic [3:0] PINS_RESET   = 4'd13;
   localparam logic [7:0] PERIOD_RESET = 8'd25;

   typedef struct packed {
      logic [2:0] op;
      logic [3:0] led_index;
   } lbm_req_type;

   typedef struct packed {
      logic [3:0] led_pins;
      logic       error;
   } lbm_rsp_type;

   typedef struct packed {
      logic [3:0]      pin_levels;
      logic [3:0]      blink_enabled;
      logic [3:0][7:0] countdown;
      logic [1:0]      red_flip_mask;
   } lbm_state_type;

   // Pin bit driven by each LED index
   function automatic logic [3:0] led_pin(input logic [1:0] idx);
      logic [3:0] mask;
      case (idx)
         LED_RED:   mask = PIN_RED;
         LED_GREEN: mask = PIN_GREEN;
         LED_DRV1:  mask = PIN_DISK1;
         LED_DRV2:  mask = PIN_DISK2;
         default:   mask = PIN_RED;
      endcase
      return mask;
   endfunction

endpackage

@@ sv/led_blink_manager.sv @@
// An accepted request passes through the input register and then the response register.
// Throughput: one request per cycle while the response is not stalled; the LED state register updates in one pass.
// A stalled response is held in the output register while one more request waits
// in the input register.
// Synchronous reset: red on, other LEDs off, all countdowns stopped, period 25.
// ----------------------------------------------------------------------------
// LED blink manager
// Drives two status LEDs and two disk LEDs with on, off, blink, alternate, all on and all off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_manager import lbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lbm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lbm_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic          req_valid_ff;
   lbm_req_type   req_data_ff;
   logic          rsp_valid_ff;
   lbm_rsp_type   rsp_data_ff;
   lbm_state_type state_ff;
   lbm_state_type state_in;
   logic [7:0]    period_ff;
   logic          core_error;
   logic          rsp_free;
   logic          advance;

   // Handshake: the input stage moves on whenever the output register is free
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && rsp_free;
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
   end

   // Blink period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_data;
      end
   end

   // Next-state logic
   lbm_core u_core (
      .cur_state    (state_ff),
      .req          (req_data_ff),
      .blink_period (period_ff),
      .nxt_state    (state_in),
      .error        (core_error)
   );

   // LED state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pin_levels    <= PINS_RESET;
         state_ff.blink_enabled <= 4'd0;
         state_ff.countdown     <= '0;
         state_ff.red_flip_mask <= 2'd0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.led_pins <= state_in.pin_levels;
         rsp_data_ff.error    <= core_error;
      end
   end

endmodule

@@ sv/lbm_core.sv @@
// ----------------------------------------------------------------------------
// LED blink manager next-state logic
// Applies one tick or command to the LED state and forms the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbm_core import lbm_pkg::*; (
   input  lbm_state_type cur_state,
   input  lbm_req_type   req,
   input  logic [7:0]    blink_period,
   output lbm_state_type nxt_state,
   output logic          error
);

   logic [1:0] idx;
   logic [3:0] pin;
   logic       active_high;
   logic [7:0] reload;

   always_comb begin
      nxt_state   = cur_state;
      error       = 1'b0;
      idx         = req.led_index[1:0];
      pin         = led_pin(idx);
      active_high = (idx == LED_RED) || (idx == LED_GREEN);
      // a zero period behaves as one
      reload      = (blink_period == 8'd0) ? 8'd1 : blink_period;

      if (req.op == OP_TICK) begin
         // every running countdown steps; expiry flips and reloads
         for (int i = 0; i < 4; i++) begin
            if (cur_state.blink_enabled[i]) begin
               if (cur_state.countdown[i] <= 8'd1) begin
                  if (i == 0) begin
                     nxt_state.pin_levels = nxt_state.pin_levels ^
                                            {2'b00, cur_state.red_flip_mask};
                  end else begin
                     nxt_state.pin_levels = nxt_state.pin_levels ^ led_pin(2'(i));
                  end
                  nxt_state.countdown[i] = reload;
               end else begin
                  nxt_state.countdown[i] = cur_state.countdown[i] - 8'd1;
               end
            end
         end
      end else if (req.led_index >= LED_COUNT) begin
         error = 1'b1;
      end else begin
         case (req.op)
            OP_ON: begin
               nxt_state.blink_enabled[idx] = 1'b0;
               nxt_state.pin_levels = active_high ? (cur_state.pin_levels | pin)
                                                  : (cur_state.pin_levels & ~pin);
            end
            OP_OFF: begin
               nxt_state.blink_enabled[idx] = 1'b0;
               nxt_state.pin_levels = active_high ? (cur_state.pin_levels & ~pin)
                                                  : (cur_state.pin_levels | pin);
            end
            OP_BLINK: begin
               nxt_state.pin_levels = active_high ? (cur_state.pin_levels | pin)
                                                  : (cur_state.pin_levels & ~pin);
               if (idx == LED_RED) begin
                  nxt_state.red_flip_mask = PIN_RED[1:0];
               end
               nxt_state.blink_enabled[idx] = 1'b1;
               nxt_state.countdown[idx]     = reload;
            end
            OP_ALT: begin
               // only red may alternate, swapping with green
               if (idx == LED_RED) begin
                  nxt_state.pin_levels = (cur_state.pin_levels | PIN_GREEN) & ~PIN_RED;
                  nxt_state.red_flip_mask = PIN_RED[1:0] | PIN_GREEN[1:0];
                  nxt_state.blink_enabled[LED_RED] = 1'b1;
                  nxt_state.countdown[LED_RED]     = reload;
               end else begin
                  error = 1'b1;
               end
            end
            OP_ALL_ON: begin
               // red keeps its level
               nxt_state.blink_enabled = 4'd0;
               nxt_state.pin_levels = (cur_state.pin_levels | PIN_GREEN) &
                                      ~(PIN_DISK1 | PIN_DISK2);
            end
            OP_ALL_OFF: begin
               nxt_state.blink_enabled = 4'd0;
               nxt_state.pin_levels = (cur_state.pin_levels & ~(PIN_RED | PIN_GREEN)) |
                                      PIN_DISK1 | PIN_DISK2;
            end
            default: begin
               error = 1'b1;
            end
         endcase
      end
   end

endmodule

@@ sv/lbm_checker.sv @@
// ----------------------------------------------------------------------------
// LED blink manager port checker
// Watches the handshakes of the block's ports; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_blink_manager_macros.svh"

module lbm_checker import lbm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input lbm_rsp_type rsp_data,
   input logic        csr_valid,
   input logic        csr_ready
);

   // A stalled response keeps its value
   `LBM_ASSERT(a_rsp_hold, clock, reset,
               rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data),
               "response changed while stalled")

   // Reset empties the output register
   `LBM_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid,
                      "response valid after reset")

   // The block only pushes back on requests while the response is stalled
   `LBM_ASSERT(a_req_ready, clock, reset, !(rsp_valid && !rsp_ready) |-> req_ready,
               "request refused without a stalled response")

   // Period writes are never refused
   `LBM_ASSERT(a_csr_ready, clock, reset, csr_valid |-> csr_ready,
               "register write refused")

endmodule

bind led_blink_manager lbm_checker u_lbm_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// LED blink manager testbench
// Random and directed requests against a cycle-free model of the LED pins,
// with random gaps and stalls on both channels, a long response hold-off and
// several blink periods. Every response is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import lbm_pkg::*;

   // Opcode the block does not know
   localparam logic [2:0] OP_BAD = 3'd7;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 60;
   localparam int END_PAUSE      = 10;
   localparam int MAX_PRINTED    = 40;

   // -------------------------------------------------------------------------
   // Pin tracker: predicts the pin levels and error flag of every request
   // -------------------------------------------------------------------------
   class pin_tracker;
      logic [3:0]  pins;
      logic [3:0]  running;
      logic [7:0]  count_left [4];
      logic [1:0]  red_flip;
      logic [7:0]  period;
      lbm_rsp_type due_pins [$];
      int          fails;
      int          requests;
      int          responses;
      int          ticks;
      int          rejects;

      function new();
         pins      = PINS_RESET;
         running   = '0;
         foreach (count_left[i]) count_left[i] = '0;
         red_flip  = '0;
         period    = PERIOD_RESET;
         fails     = 0;
         requests  = 0;
         responses = 0;
         ticks     = 0;
         rejects   = 0;
      endfunction

      function logic [3:0] pin_bit(input logic [1:0] led);
         case (led)
            LED_RED:   return PIN_RED;
            LED_GREEN: return PIN_GREEN;
            LED_DRV1:  return PIN_DISK1;
            default:   return PIN_DISK2;
         endcase
      endfunction

      // Status LEDs are active high, disk LEDs active low
      function void light(input logic [1:0] led, input bit lit);
         bit level;
         level = (led == LED_RED || led == LED_GREEN) ? lit : !lit;
         if (level) pins = pins | pin_bit(led);
         else       pins = pins & ~pin_bit(led);
      endfunction

      function logic [7:0] reload();
         return (period == 8'd0) ? 8'd1 : period;
      endfunction

      function void set_period(input logic [7:0] value);
         period = value;
      endfunction

      function int pending();
         return due_pins.size();
      endfunction

      // Work out the response to one accepted request
      function void note(input lbm_req_type r);
         lbm_rsp_type outcome;
         logic [1:0]  led;
         bit          err;
         err = 1'b0;
         led = r.led_index[1:0];
         requests++;
         if (r.op == OP_TICK) begin
            ticks++;
            for (int i = 0; i < 4; i++) begin
               if (running[i]) begin
                  if (count_left[i] <= 8'd1) begin
                     pins = pins ^ ((i == 0) ? {2'b00, red_flip} : pin_bit(2'(i)));
                     count_left[i] = reload();
                  end else begin
                     count_left[i] = count_left[i] - 8'd1;
                  end
               end
            end
         end else if (r.led_index >= LED_COUNT) begin
            err = 1'b1;
         end else begin
            case (r.op)
               OP_ON: begin
                  running[led] = 1'b0;
                  light(led, 1'b1);
               end
               OP_OFF: begin
                  running[led] = 1'b0;
                  light(led, 1'b0);
               end
               OP_BLINK: begin
                  light(led, 1'b1);
                  if (led == LED_RED) red_flip = PIN_RED[1:0];
                  running[led]    = 1'b1;
                  count_left[led] = reload();
               end
               OP_ALT: begin
                  if (led == LED_RED) begin
                     light(LED_GREEN, 1'b1);
                     light(LED_RED, 1'b0);
                     red_flip            = PIN_RED[1:0] | PIN_GREEN[1:0];
                     running[LED_RED]    = 1'b1;
                     count_left[LED_RED] = reload();
                  end else begin
                     err = 1'b1;
                  end
               end
               OP_ALL_ON: begin
                  running = '0;
                  pins    = (pins | PIN_GREEN) & ~(PIN_DISK1 | PIN_DISK2);
               end
               OP_ALL_OFF: begin
                  running = '0;
                  pins    = (pins & ~(PIN_RED | PIN_GREEN)) | PIN_DISK1 | PIN_DISK2;
               end
               default: err = 1'b1;
            endcase
         end
         if (err) rejects++;
         outcome.led_pins = pins;
         outcome.error    = err;
         due_pins.push_back(outcome);
      endfunction

      task report(input string what);
         fails++;
         if (fails <= MAX_PRINTED) $display("mismatch: %s", what);
      endtask

      // Compare one response with the oldest prediction
      task check(input lbm_rsp_type got);
         lbm_rsp_type want;
         responses++;
         if (due_pins.size() == 0) begin
            report($sformatf("response %0d arrived with nothing outstanding", responses));
         end else begin
            want = due_pins.pop_front();
            if (got.led_pins !== want.led_pins)
               report($sformatf("response %0d: led_pins %h, wanted %h",
                                responses, got.led_pins, want.led_pins));
            if (got.error !== want.error)
               report($sformatf("response %0d: error %b, wanted %b",
                                responses, got.error, want.error));
         end
      endtask
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   lbm_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   lbm_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data  = PERIOD_RESET;

   pin_tracker  tracker;
   bit          no_idle      = 1'b0;
   bit          hold_request = 1'b0;
   int          quiet_cycles = 0;
   int          settings_used = 1;

   led_blink_manager i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   // Offer one request, keeping valid high across back-to-back requests
   task automatic send_req(input logic [2:0] op, input logic [3:0] led_index);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.op        <= op;
      req_data.led_index <= led_index;
      do @(posedge clock); while (!req_ready);
      tracker.note(req_data);
   endtask

   // Period writes only once every response is back
   task automatic write_period(input logic [7:0] value);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_period(value);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Mostly ticks and well-formed commands, with some bad indexes and opcodes
   function automatic lbm_req_type rand_req();
      lbm_req_type r;
      int          pick;
      pick        = $urandom_range(0, 99);
      r.led_index = 4'($urandom_range(0, 15));
      if (pick < 45) begin
         r.op = OP_TICK;
      end else if (pick < 92) begin
         case ($urandom_range(0, 7))
            0:       r.op = OP_ON;
            1:       r.op = OP_OFF;
            2, 3:    r.op = OP_BLINK;
            4, 5:    r.op = OP_ALT;
            6:       r.op = OP_ALL_ON;
            default: r.op = OP_ALL_OFF;
         endcase
         if ($urandom_range(0, 9) != 0) r.led_index = 4'($urandom_range(0, 3));
         if (r.op == OP_ALT && $urandom_range(0, 2) != 0) r.led_index = {2'b00, LED_RED};
      end else begin
         r.op = OP_BAD;
      end
      return r;
   endfunction

   task automatic run_random(input int count);
      lbm_req_type r;
      repeat (count) begin
         r = rand_req();
         send_req(r.op, r.led_index);
      end
   endtask

   // Hand-picked sequence, run with a period of one
   task automatic run_directed();
      send_req(OP_BLINK,   4'd0);
      send_req(OP_TICK,    4'd0);
      send_req(OP_TICK,    4'd15);
      send_req(OP_ALT,     4'd0);
      send_req(OP_TICK,    4'd0);
      send_req(OP_TICK,    4'd7);
      send_req(OP_ALT,     4'd1);
      send_req(OP_BLINK,   4'd1);
      send_req(OP_BLINK,   4'd2);
      send_req(OP_BLINK,   4'd3);
      send_req(OP_TICK,    4'd0);
      send_req(OP_BLINK,   4'd0);
      send_req(OP_TICK,    4'd0);
      send_req(OP_ON,      4'd2);
      send_req(OP_OFF,     4'd3);
      send_req(OP_TICK,    4'd0);
      send_req(OP_ALL_ON,  4'd0);
      send_req(OP_TICK,    4'd0);
      send_req(OP_BLINK,   4'd3);
      send_req(OP_ALL_OFF, 4'd0);
      send_req(OP_TICK,    4'd0);
      send_req(OP_BAD,     4'd0);
      send_req(OP_ON,      4'd15);
      send_req(OP_ALL_ON,  4'd4);
      send_req(OP_ALL_OFF, 4'd8);
      send_req(OP_OFF,     4'd0);
      send_req(OP_ON,      4'd1);
   endtask

   // Response side: random stalls, one long hold-off on request
   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall        = LONG_HOLD;
         end else begin
            stall = draw_wait();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         tracker.check(rsp_data);
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin : req_side
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset period first
      run_random(80);

      write_period(8'd1);
      run_directed();

      write_period(8'd255);
      run_random(60);

      // zero period, no idling on either side
      write_period(8'd0);
      no_idle = 1'b1;
      run_random(80);
      no_idle = 1'b0;

      // long response hold-off while requests keep coming
      write_period(8'd3);
      hold_request = 1'b1;
      run_random(120);

      write_period(8'($urandom_range(2, 8)));
      run_random(120);

      write_period(8'd2);
      run_random(120);

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);

      $display("covered %0d requests (%0d ticks, %0d rejected), %0d responses checked",
               tracker.requests, tracker.ticks, tracker.rejects, tracker.responses);
      $display("over %0d blink periods incl. 0, 1 and 255, with a long response stall",
               settings_used);
      if (tracker.fails == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", tracker.fails);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/lbm_pkg.sv
sv/lbm_core.sv
sv/led_blink_manager.sv
sv/lbm_checker.sv
tb/tb.sv
